[sv/lvg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luma video line generator package
// Shared types, register indexes and arithmetic constants of the generator.
// ----------------------------------------------------------------------------
package lvg_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 3'd0,
    CFG_ACTIVE_HEIGHT = 3'd1,
    CFG_HSYNC_LEN     = 3'd2,
    CFG_VSYNC_LINES   = 3'd3,
    CFG_SYNC_LEVEL    = 3'd4,
    CFG_BLACK_LEVEL   = 3'd5,
    CFG_WHITE_LEVEL   = 3'd6
  } cfg_idx_t;

  // Raster regions of the timing counters.
  typedef enum logic [1:0] {
    RG_VSYNC  = 2'd0,
    RG_HSYNC  = 2'd1,
    RG_ACTIVE = 2'd2
  } region_t;

  // Q16 BT.709 luma weights.
  localparam logic [15:0] LUMA_KR = 16'd13933;
  localparam logic [15:0] LUMA_KG = 16'd46871;
  localparam logic [15:0] LUMA_KB = 16'd4732;

  // Division by 255: the quotient is offset so that the dividend is never
  // negative, then found by an exact reciprocal multiply.
  localparam logic [25:0] DIV_OFFSET  = 26'd16711680;
  localparam logic [26:0] RECIP_255   = 27'd67372037;
  localparam int          RECIP_SHIFT = 34;
  localparam logic [18:0] QUOT_BIAS   = 19'd65536;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sd32767;

  // Queue between the timing front and the arithmetic back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Effective raster geometry.
  typedef struct packed {
    logic [10:0] aw;
    logic [10:0] ah;
    logic [7:0]  hs;
    logic [7:0]  vs;
  } geom_t;

  // Output levels.
  typedef struct packed {
    logic signed [15:0] sync;
    logic signed [15:0] black;
    logic signed [15:0] white;
  } levels_t;

  // One classified sample slot.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_pixel;
    logic       frame_start;
  } slot_t;

endpackage

[sv/lvg_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface lvg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[sv/lvg_smp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample output channel
// Valid/ready channel carrying one baseband sample and its flags per transfer.
// ----------------------------------------------------------------------------
interface lvg_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               pixel_taken;
  logic               frame_start;

  modport source (output valid, output sample, output pixel_taken, output frame_start,
                  input ready);
  modport sink   (input valid, input sample, input pixel_taken, input frame_start,
                  output ready);
endinterface

[sv/lvg_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lvg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/lvg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot queue
// Short first-in first-out queue of classified slots between front and back.
// ----------------------------------------------------------------------------
module lvg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lvg_pkg::slot_t push_slot,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output lvg_pkg::slot_t head
);
  import lvg_pkg::*;

  slot_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_slot;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);

endmodule

[sv/lvg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster timing front
// Accepts input slots, runs the raster counters and classifies each slot as
// sync or pixel, marking the first slot of a frame.
// ----------------------------------------------------------------------------
module lvg_front (
  input  logic           clk,
  input  logic           rst_n,
  lvg_pix_if.sink        in_if,
  input  lvg_pkg::geom_t geom,
  input  logic           full,
  output logic           push,
  output lvg_pkg::slot_t push_slot
);
  import lvg_pkg::*;

  typedef struct packed {
    region_t     region;
    logic [11:0] col;
    logic [10:0] line;
  } tmg_t;

  region_t     region_r, region_nxt;
  logic [11:0] col_r, col_nxt;
  logic [10:0] line_r, line_nxt;
  tmg_t        settled;
  logic        accept;

  // One step of moving the counters on to a slot that exists; holds the
  // position when it already names one.
  function automatic tmg_t settle_step(tmg_t s, geom_t g);
    tmg_t        n;
    logic [11:0] line_len;
    logic [10:0] line_inc;
    n        = s;
    line_len = {1'b0, g.aw} + {4'b0, g.hs};
    line_inc = s.line + 11'd1;
    case (s.region)
      RG_VSYNC: begin
        if (s.col >= line_len) begin
          n.col  = '0;
          n.line = line_inc;
        end else if (s.line >= {3'b0, g.vs}) begin
          n.region = RG_HSYNC;
          n.line   = '0;
          n.col    = '0;
        end
      end
      RG_HSYNC: begin
        if (s.col >= {4'b0, g.hs}) begin
          n.region = RG_ACTIVE;
          n.col    = '0;
        end
      end
      RG_ACTIVE: begin
        if (s.col >= {1'b0, g.aw}) begin
          n.col = '0;
          if (line_inc >= g.ah) begin
            n.region = RG_VSYNC;
            n.line   = '0;
          end else begin
            n.region = RG_HSYNC;
            n.line   = line_inc;
          end
        end
      end
      default: begin
        n.region = RG_VSYNC;
        n.col    = '0;
        n.line   = '0;
      end
    endcase
    return n;
  endfunction

  assign in_if.ready = !full;
  assign accept      = in_if.valid && !full;
  assign push        = accept;

  // Settle the counters, classify the slot and step the column on.
  always_comb begin
    settled = '{region: region_r, col: col_r, line: line_r};
    // At most four region changes happen before a real slot is reached.
    for (int i = 0; i < 4; i++) begin
      settled = settle_step(settled, geom);
    end

    push_slot.red         = in_if.red;
    push_slot.green       = in_if.green;
    push_slot.blue        = in_if.blue;
    push_slot.is_pixel    = (settled.region == RG_ACTIVE);
    push_slot.frame_start = (settled.line == '0) && (settled.col == '0) &&
                            ((settled.region == RG_VSYNC) ||
                             (settled.region == RG_HSYNC && geom.vs == '0) ||
                             (settled.region == RG_ACTIVE && geom.vs == '0 &&
                              geom.hs == '0));

    region_nxt = region_r;
    col_nxt    = col_r;
    line_nxt   = line_r;
    if (accept) begin
      region_nxt = settled.region;
      col_nxt    = settled.col + 12'd1;
      line_nxt   = settled.line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= RG_VSYNC;
      col_r    <= '0;
      line_r   <= '0;
    end else begin
      region_r <= region_nxt;
      col_r    <= col_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

[sv/lvg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample arithmetic back
// Pipeline that turns classified slots into clamped baseband samples: luma,
// level scaling, division by 255 and the output register.
// ----------------------------------------------------------------------------
module lvg_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  lvg_pkg::slot_t   head,
  output logic             pop,
  input  lvg_pkg::levels_t lvl,
  lvg_smp_if.source        out_if
);
  import lvg_pkg::*;

  logic               adv;

  logic               a_vld_r, a_pix_r, a_fs_r;
  logic [23:0]        a_y_r;
  logic signed [16:0] a_diff_r;

  logic               b_vld_r, b_pix_r, b_fs_r;
  logic signed [40:0] b_num_r;

  logic               c_vld_r, c_pix_r, c_fs_r;
  logic [25:0]        c_u_r;

  logic               d_vld_r, d_pix_r, d_fs_r;
  logic [16:0]        d_q_r;

  logic               out_vld_r;
  logic signed [15:0] out_sample_r;
  logic               out_pix_r, out_fs_r;

  logic [23:0]        y_nxt;
  logic signed [16:0] diff_nxt;
  logic signed [41:0] num_full;
  logic [25:0]        u_nxt;
  logic [52:0]        prod;
  logic signed [18:0] pix_sum;
  logic signed [15:0] sample_nxt;

  // The whole pipe moves when the output register is free or being emptied.
  assign adv = !out_vld_r || out_if.ready;
  assign pop = adv && !empty;

  // Stage A: luma and level span.
  always_comb begin
    y_nxt    = 24'(LUMA_KR * 24'(head.red)) + 24'(LUMA_KG * 24'(head.green)) +
               24'(LUMA_KB * 24'(head.blue));
    diff_nxt = {lvl.white[15], lvl.white} - {lvl.black[15], lvl.black};
  end

  // Stage B: scaled luma; Stage C: shifted and offset dividend.
  always_comb begin
    num_full = a_diff_r * $signed({1'b0, a_y_r});
    u_nxt    = 26'({b_num_r[40], b_num_r[40:16]} + DIV_OFFSET);
    prod     = 53'(c_u_r) * 53'(RECIP_255);
  end

  // Output stage: add black level and clamp; sync slots give the clamped
  // sync level.
  always_comb begin
    pix_sum = $signed({2'b0, d_q_r}) - $signed(QUOT_BIAS) +
              19'(lvl.black);
    if (d_pix_r) begin
      if (pix_sum > 19'(SAMPLE_MAX)) begin
        sample_nxt = SAMPLE_MAX;
      end else if (pix_sum < 19'(SAMPLE_MIN)) begin
        sample_nxt = SAMPLE_MIN;
      end else begin
        sample_nxt = pix_sum[15:0];
      end
    end else begin
      sample_nxt = (lvl.sync < SAMPLE_MIN) ? SAMPLE_MIN : lvl.sync;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= !empty;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      out_vld_r <= d_vld_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_y_r        <= y_nxt;
      a_diff_r     <= diff_nxt;
      a_pix_r      <= head.is_pixel;
      a_fs_r       <= head.frame_start;
      b_num_r      <= num_full[40:0];
      b_pix_r      <= a_pix_r;
      b_fs_r       <= a_fs_r;
      c_u_r        <= u_nxt;
      c_pix_r      <= b_pix_r;
      c_fs_r       <= b_fs_r;
      d_q_r        <= prod[RECIP_SHIFT+16:RECIP_SHIFT];
      d_pix_r      <= c_pix_r;
      d_fs_r       <= c_fs_r;
      out_sample_r <= sample_nxt;
      out_pix_r    <= d_pix_r;
      out_fs_r     <= d_fs_r;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.sample      = out_sample_r;
  assign out_if.pixel_taken = out_pix_r;
  assign out_if.frame_start = out_fs_r;

endmodule

[sv/luma_video_line_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luma video line generator
// Emits one baseband sample per input slot: sync lines, sync pulses and
// BT.709 luma pixels scaled between the black and white levels.
//
//   Channel  Direction  Transfer carries
//   in_if    in         red, green, blue of the next pixel
//   out_if   out        sample, pixel_taken, frame_start
//   cfg_if   in         register index and write data
//
// Sustained rate is one slot per clock unless the output stalls, set by the
// raster counter update in the front. A slot passes the queue and stage
// registers A to D into the output register. Reset is synchronous and no
// clearing pass is needed. A stall on the output freezes the arithmetic
// pipe; the front keeps taking slots until the four-entry queue is full.
// ----------------------------------------------------------------------------
module luma_video_line_generator_core (
  input  logic      clk,
  input  logic      rst_n,
  lvg_pix_if.sink   in_if,
  lvg_smp_if.source out_if,
  lvg_cfg_if.sink   cfg_if
);
  import lvg_pkg::*;

  logic [10:0]        aw_r;
  logic [10:0]        ah_r;
  logic [7:0]         hs_r;
  logic [7:0]         vs_r;
  logic signed [15:0] sync_r;
  logic signed [15:0] black_r;
  logic signed [15:0] white_r;

  geom_t   geom;
  levels_t lvl;
  logic    push, pop, full, empty;
  slot_t   push_slot, head;

  // Register file; writes beyond the list are dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r    <= 11'd640;
      ah_r    <= 11'd480;
      hs_r    <= 8'd5;
      vs_r    <= 8'd10;
      sync_r  <= -16'sd32767;
      black_r <= -16'sd16383;
      white_r <= 16'sd32767;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_ACTIVE_WIDTH:  aw_r    <= cfg_if.data[10:0];
        CFG_ACTIVE_HEIGHT: ah_r    <= cfg_if.data[10:0];
        CFG_HSYNC_LEN:     hs_r    <= cfg_if.data[7:0];
        CFG_VSYNC_LINES:   vs_r    <= cfg_if.data[7:0];
        CFG_SYNC_LEVEL:    sync_r  <= cfg_if.data;
        CFG_BLACK_LEVEL:   black_r <= cfg_if.data;
        CFG_WHITE_LEVEL:   white_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // A zero width or height counts as one.
  always_comb begin
    geom.aw   = (aw_r == '0) ? 11'd1 : aw_r;
    geom.ah   = (ah_r == '0) ? 11'd1 : ah_r;
    geom.hs   = hs_r;
    geom.vs   = vs_r;
    lvl.sync  = sync_r;
    lvl.black = black_r;
    lvl.white = white_r;
  end

  lvg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .geom      (geom),
    .full      (full),
    .push      (push),
    .push_slot (push_slot)
  );

  lvg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_slot (push_slot),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  lvg_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .lvl    (lvl),
    .out_if (out_if)
  );

endmodule

[sv/lvg_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luma video line generator checker
// Port-level checks of the generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lvg_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_sample,
  input logic              out_frame_start
);
  logic [3:0] pend_r, pend_nxt;
  logic       seen_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Count of slots taken whose samples are not yet transferred.
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 4'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (out_xfer) begin
        seen_r <= 1'b1;
      end
    end
  end

  // No sample appears without a slot behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("sample offered with no slot outstanding");

  // The first sample after reset opens a frame.
  a_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_r |-> out_frame_start)
    else $error("first sample after reset does not start a frame");

  // Samples stay inside the clamp range.
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != 16'sh8000)
    else $error("sample outside clamp range");

  // A stalled sample is held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled sample changed");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("sample offered straight after reset");

endmodule

bind luma_video_line_generator_core lvg_chk u_lvg_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_sample      (out_if.sample),
  .out_frame_start (out_if.frame_start)
);
